// ----- hdl/bfha_pkg.sv -----
// ----------------------------------------------------------------------------
// bfha_pkg
// Types, codes and default sizes shared by the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

	localparam int START_W = 16;
	localparam int LEN_W   = 17;
	localparam int NEED_W  = 18;

	localparam int DEF_HEAP_BYTES   = 65536;
	localparam int DEF_MIN_PAYLOAD  = 16;
	localparam int DEF_HEADER_BYTES = 24;
	localparam int DEF_MAX_BLOCKS   = 64;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_NO_FIT   = 2'd2;
	localparam logic [1:0] ST_BAD_ADDR = 2'd3;

	typedef struct packed {
		logic               valid;
		logic               free;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} entry_t;

	typedef struct packed {
		logic               flush;
		logic               kind;
		logic [NEED_W-1:0]  need;
		logic [START_W-1:0] best_start;
		logic [START_W-1:0] addr;
		logic               room;
	} ctrl_t;

	typedef struct packed {
		logic               split;
		logic               merge;
		logic               hit;
		logic [START_W-1:0] grant;
	} ev_t;

endpackage

// ----- hdl/best_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit heap allocator with coalescing; the block table is a ring of
// cells rotated past one stream stage.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   in      | in_valid/in_stall  | kind, request_size, release_address
//   out     | out_valid/out_stall| status, payload_address
//
// One request at a time. Allocate: align the ring on the heap start, search
// it, then rewrite it. Free skips the search. A bad size or a null free goes
// straight to the answer. Reset leaves one free block over the whole heap.
// A stalled result holds in the output register; the next request is taken
// meanwhile.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator
	import bfha_pkg::*;
#(
	parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
	parameter int MIN_PAYLOAD  = DEF_MIN_PAYLOAD,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [LEN_W-1:0]    request_size,
	input  logic [START_W-1:0]  release_address,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [START_W-1:0]  payload_address
);

	localparam int CW = $clog2(MAX_BLOCKS);
	localparam int NW = $clog2(MAX_BLOCKS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ALIGN = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_PROC  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [NW-1:0]      count_q;
	logic               kind_q;
	logic [NEED_W-1:0]  need_q;
	logic [START_W-1:0] addr_q;
	logic               found_q;
	logic [START_W-1:0] best_start_q;
	logic [LEN_W-1:0]   best_len_q;
	logic [START_W-1:0] grant_q;
	logic [1:0]         res_st_q;
	logic [START_W-1:0] res_addr_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [START_W-1:0] paddr_q;

	entry_t ring [MAX_BLOCKS];
	entry_t tail, ring_in, proc_y;
	logic   shift, proc_en, drained, accept, last, better, aligned;
	logic   [LEN_W-1:0]  size_eff;
	ctrl_t  ctrl;
	ev_t    ev;

	assign tail    = ring[MAX_BLOCKS-1];
	assign aligned = tail.valid && tail.start == '0;
	assign shift   = (state_q == S_ALIGN && !aligned) || state_q == S_SCAN || proc_en;
	assign proc_en = state_q == S_PROC || state_q == S_FLUSH;
	assign ring_in = proc_en ? proc_y : tail;
	assign accept  = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign last    = cnt_q == CW'(MAX_BLOCKS - 1);
	assign size_eff = (request_size < LEN_W'(MIN_PAYLOAD)) ? LEN_W'(MIN_PAYLOAD)
		: request_size;
	assign better  = tail.valid && tail.free && {1'b0, tail.len} >= need_q
		&& (!found_q || tail.len < best_len_q
		|| (tail.len == best_len_q && tail.start < best_start_q));

	assign ctrl.flush      = state_q == S_FLUSH;
	assign ctrl.kind       = kind_q;
	assign ctrl.need       = need_q;
	assign ctrl.best_start = best_start_q;
	assign ctrl.addr       = addr_q;
	assign ctrl.room       = count_q < NW'(MAX_BLOCKS);

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		bfha_cell #(
			.HEAP_BYTES (HEAP_BYTES),
			.IS_HEAD    (i == MAX_BLOCKS - 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      ((i == 0) ? ring_in : ring[(i == 0) ? 0 : i-1]),
			.q      (ring[i])
		);
	end

	bfha_proc #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_proc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (proc_en),
		.ctrl    (ctrl),
		.x       (tail),
		.y       (proc_y),
		.drained (drained),
		.ev      (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			count_q     <= NW'(1);
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						if (kind == KIND_ALLOC) begin
							if (request_size == '0 || request_size > LEN_W'(HEAP_BYTES))
								state_q <= S_DONE;
							else state_q <= S_ALIGN;
						end else begin
							if (release_address == '0) state_q <= S_DONE;
							else state_q <= S_ALIGN;
						end
					end
				end
				S_ALIGN: begin
					if (aligned)
						state_q <= (kind_q == KIND_ALLOC) ? S_SCAN : S_PROC;
				end
				S_SCAN: begin
					if (better) found_q <= 1'b1;
					cnt_q <= last ? '0 : cnt_q + CW'(1);
					if (last) begin
						state_q <= (found_q || better) ? S_PROC : S_DONE;
					end
				end
				S_PROC: begin
					if (ev.hit) found_q <= 1'b1;
					if (ev.split) count_q <= count_q + NW'(1);
					else if (ev.merge) count_q <= count_q - NW'(1);
					cnt_q <= last ? '0 : cnt_q + CW'(1);
					if (last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (drained) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind;
			need_q     <= {1'b0, size_eff} + NEED_W'(HEADER_BYTES);
			addr_q     <= release_address;
			res_st_q   <= (kind == KIND_ALLOC) ? ST_BAD_SIZE : ST_OK;
			res_addr_q <= '0;
		end
		if (state_q == S_SCAN && better) begin
			best_start_q <= tail.start;
			best_len_q   <= tail.len;
		end
		if (state_q == S_SCAN && last && !(found_q || better)) res_st_q <= ST_NO_FIT;
		if (state_q == S_PROC && ev.hit) grant_q <= ev.grant;
		if (state_q == S_FLUSH && drained) begin
			if (kind_q == KIND_ALLOC) begin
				res_st_q   <= ST_OK;
				res_addr_q <= grant_q;
			end else begin
				res_st_q <= found_q ? ST_OK : ST_BAD_ADDR;
			end
		end
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			status_q <= res_st_q;
			paddr_q  <= res_addr_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign payload_address = paddr_q;

endmodule

// ----- hdl/bfha_cell.sv -----
// ----------------------------------------------------------------------------
// bfha_cell
// One slot of the block table ring; takes its neighbour's entry on shift.
// ----------------------------------------------------------------------------
module bfha_cell
	import bfha_pkg::*;
#(
	parameter int HEAP_BYTES = DEF_HEAP_BYTES,
	parameter bit IS_HEAD    = 1'b0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.valid <= IS_HEAD;
			ent_q.free  <= IS_HEAD;
			ent_q.start <= '0;
			ent_q.len   <= IS_HEAD ? LEN_W'(HEAP_BYTES) : '0;
		end else if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule

// ----- hdl/bfha_proc.sv -----
// ----------------------------------------------------------------------------
// bfha_proc
// Stream stage between ring tail and head: marks, splits and merges entries,
// with a two-entry queue so that a split can be absorbed by later empty slots.
// ----------------------------------------------------------------------------
module bfha_proc
	import bfha_pkg::*;
#(
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  ctrl_t  ctrl,
	input  entry_t x,
	output entry_t y,
	output logic   drained,
	output ev_t    ev
);

	entry_t     q0_q, q1_q;
	logic [1:0] qn_q;

	entry_t     q0_d, q1_d;
	logic [1:0] qn_d;

	always_comb begin
		entry_t            xm, tl, ap0, ap1, bub;
		entry_t            l0, l1, l2;
		logic [NEED_W-1:0] rest;
		logic              hit_a, hit_f, split, merge, emit;
		logic [1:0]        n;
		bub   = '0;
		xm    = x;
		rest  = {1'b0, x.len} - ctrl.need;
		hit_a = !ctrl.flush && ctrl.kind == KIND_ALLOC && x.valid
			&& x.start == ctrl.best_start;
		hit_f = !ctrl.flush && ctrl.kind == KIND_FREE && x.valid
			&& ({1'b0, x.start} + LEN_W'(HEADER_BYTES)) == {1'b0, ctrl.addr};
		split = hit_a && rest > NEED_W'(HEADER_BYTES) && ctrl.room;
		if (hit_f) xm.free = 1'b1;
		if (hit_a) xm.free = 1'b0;
		tl    = (qn_q == 2'd2) ? q1_q : q0_q;
		merge = !ctrl.flush && ctrl.kind == KIND_FREE && xm.valid && xm.free
			&& qn_q != 2'd0 && tl.free
			&& ({1'b0, tl.start} + tl.len) == {1'b0, xm.start};
		l0 = q0_q;
		l1 = q1_q;
		l2 = bub;
		n  = qn_q;
		if (merge) begin
			if (qn_q == 2'd2) l1.len = q1_q.len + xm.len;
			else l0.len = q0_q.len + xm.len;
		end
		ap0 = '{valid: 1'b1, free: 1'b0, start: x.start, len: ctrl.need[LEN_W-1:0]};
		ap1 = '{valid: 1'b1, free: 1'b1, start: x.start + ctrl.need[START_W-1:0],
			len: rest[LEN_W-1:0]};
		if (split) begin
			case (n)
				2'd0: begin l0 = ap0; l1 = ap1; end
				default: begin l1 = ap0; l2 = ap1; end
			endcase
			n = n + 2'd2;
		end else if (xm.valid && !merge) begin
			case (n)
				2'd0: l0 = xm;
				2'd1: l1 = xm;
				default: l2 = xm;
			endcase
			n = n + 2'd1;
		end
		emit = ctrl.flush ? (n != 2'd0) : (n >= 2'd2);
		if (emit) begin
			y    = l0;
			q0_d = l1;
			q1_d = l2;
			qn_d = n - 2'd1;
		end else begin
			y    = bub;
			q0_d = l0;
			q1_d = l1;
			qn_d = n;
		end
		ev.split = split;
		ev.merge = merge;
		ev.hit   = hit_a || hit_f;
		ev.grant = x.start + START_W'(HEADER_BYTES);
	end

	assign drained = (qn_d == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q <= 2'd0;
		end else if (en) begin
			qn_q <= qn_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q0_q <= q0_d;
			q1_q <= q1_d;
		end
	end

endmodule

// ----- hdl/bfha_checker.sv -----
// ----------------------------------------------------------------------------
// bfha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfha_checker
	import bfha_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [1:0]          status,
	input logic [START_W-1:0]  payload_address
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_address))
		else $error("stalled result changed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_address == '0)
		else $error("failed request carries an address");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in progress");

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.payload_address (payload_address)
);

// ----- sim/tb_best_fit_heap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_heap_allocator
// Drives allocate and free requests into the best-fit heap allocator and
// checks every result against a heap-table model kept in the bench.
// ----------------------------------------------------------------------------

class heap_scoreboard;
	localparam int HEAP   = bfha_pkg::DEF_HEAP_BYTES;
	localparam int MINP   = bfha_pkg::DEF_MIN_PAYLOAD;
	localparam int HDR    = bfha_pkg::DEF_HEADER_BYTES;
	localparam int BLOCKS = bfha_pkg::DEF_MAX_BLOCKS;

	int unsigned blk_start [BLOCKS];
	int unsigned blk_len [BLOCKS];
	bit blk_free [BLOCKS];
	int unsigned blk_count;
	logic [1:0] exp_status [$];
	logic [15:0] exp_addr [$];
	int errors;
	int n_checked;
	int n_split;
	int n_merge;
	int st_seen [4];

	function new();
		blk_start[0] = 0;
		blk_len[0] = HEAP;
		blk_free[0] = 1;
		blk_count = 1;
	endfunction

	function void push(logic [1:0] s, int unsigned a);
		exp_status.push_back(s);
		exp_addr.push_back(a[15:0]);
	endfunction

	function void merge_runs();
		int unsigned w;
		w = 0;
		for (int unsigned r = 1; r < blk_count; r++) begin
			if (blk_free[w] && blk_free[r]) begin
				blk_len[w] += blk_len[r];
				n_merge++;
			end else begin
				w++;
				blk_start[w] = blk_start[r];
				blk_len[w] = blk_len[r];
				blk_free[w] = blk_free[r];
			end
		end
		blk_count = w + 1;
	endfunction

	function void note_request(logic k, logic [16:0] sz, logic [15:0] ra);
		int unsigned need;
		int unsigned best;
		int unsigned rest;
		int unsigned size;
		bit found;
		found = 0;
		best = 0;
		if (k == bfha_pkg::KIND_ALLOC) begin
			size = sz;
			if (size == 0 || size > HEAP) begin
				push(bfha_pkg::ST_BAD_SIZE, 0);
				return;
			end
			if (size < MINP) size = MINP;
			need = size + HDR;
			for (int unsigned i = 0; i < blk_count; i++)
				if (blk_free[i] && blk_len[i] >= need)
					if (!found || blk_len[i] < blk_len[best]) begin
						best = i;
						found = 1;
					end
			if (!found) begin
				push(bfha_pkg::ST_NO_FIT, 0);
				return;
			end
			rest = blk_len[best] - need;
			if (rest > HDR && blk_count < BLOCKS) begin
				for (int unsigned i = blk_count; i > best + 1; i--) begin
					blk_start[i] = blk_start[i-1];
					blk_len[i] = blk_len[i-1];
					blk_free[i] = blk_free[i-1];
				end
				blk_start[best+1] = blk_start[best] + need;
				blk_len[best+1] = rest;
				blk_free[best+1] = 1;
				blk_len[best] = need;
				blk_count++;
				n_split++;
			end
			blk_free[best] = 0;
			push(bfha_pkg::ST_OK, blk_start[best] + HDR);
		end else begin
			if (ra == 0) begin
				push(bfha_pkg::ST_OK, 0);
				return;
			end
			for (int unsigned i = 0; i < blk_count; i++)
				if (blk_start[i] + HDR == ra) begin
					blk_free[i] = 1;
					found = 1;
					break;
				end
			if (!found) begin
				push(bfha_pkg::ST_BAD_ADDR, 0);
				return;
			end
			merge_runs();
			push(bfha_pkg::ST_OK, 0);
		end
	endfunction

	// pick the payload offset of a random live block, or 0 if none
	function int unsigned pick_used();
		int unsigned c [$];
		for (int unsigned i = 0; i < blk_count; i++)
			if (!blk_free[i]) c.push_back(blk_start[i] + HDR);
		if (c.size() == 0) return 0;
		return c[$urandom_range(c.size() - 1)];
	endfunction

	task check_result(logic [1:0] s, logic [15:0] a);
		logic [1:0] es;
		logic [15:0] ea;
		n_checked++;
		if (exp_status.size() == 0) begin
			report($sformatf("result with nothing pending: status %0d addr %0d", s, a));
			return;
		end
		es = exp_status.pop_front();
		ea = exp_addr.pop_front();
		st_seen[es]++;
		if (s !== es)
			report($sformatf("result %0d status %0d, want %0d", n_checked, s, es));
		if (a !== ea)
			report($sformatf("result %0d address %0d, want %0d", n_checked, a, ea));
	endtask

	task report(string msg);
		errors++;
		if (errors <= 40) $display("MISMATCH: %s", msg);
	endtask
endclass

module tb_best_fit_heap_allocator;
	import bfha_pkg::*;

	localparam int CYCLE_LIMIT = 1200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic kind;
	logic [LEN_W-1:0] request_size;
	logic [START_W-1:0] release_address;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic [START_W-1:0] payload_address;

	heap_scoreboard sb;
	int cycle;
	int n_sent;
	bit calm;
	bit hold_off;
	bit sending_done;

	best_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .request_size(request_size), .release_address(release_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .payload_address(payload_address)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 0;
		in_valid = 0;
		kind = KIND_ALLOC;
		request_size = 0;
		release_address = 0;
		out_stall = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, none while calm, solid during hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(status, payload_address);
			out_stall <= hold_off ? 1'b1 : (calm ? 1'b0 : ($urandom_range(99) < 36));
		end
	end

	// offer one request and hold it until taken
	task automatic send(logic k, logic [16:0] sz, logic [15:0] ra);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		request_size <= sz;
		release_address <= ra;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(k, sz, ra);
		n_sent++;
	endtask

	task automatic send_random();
		int unsigned r;
		int unsigned a;
		r = $urandom_range(99);
		if (r < 45) begin
			case ($urandom_range(3))
				0: send(KIND_ALLOC, 17'($urandom_range(32)), 16'($urandom));
				1: send(KIND_ALLOC, 17'($urandom_range(2000)), 16'($urandom));
				2: send(KIND_ALLOC, 17'($urandom_range(200, 65536)), 16'($urandom));
				default: send(KIND_ALLOC, 17'($urandom_range(130000)), 16'($urandom));
			endcase
		end else if (r < 85) begin
			a = sb.pick_used();
			send(KIND_FREE, 17'($urandom), 16'(a));
		end else if (r < 92) begin
			send(KIND_FREE, 17'($urandom), 16'($urandom));
		end else if (r < 96) begin
			send(KIND_FREE, 17'($urandom), 0);
		end else begin
			a = sb.blk_start[$urandom_range(sb.blk_count - 1)] + DEF_HEADER_BYTES;
			send(KIND_FREE, 17'($urandom), 16'(a));
		end
	endtask

	initial begin
		calm = 0;
		hold_off = 0;
		@(posedge arst_n);
		@(posedge clk);
		send(KIND_ALLOC, 0, 16'hFFFF);
		send(KIND_ALLOC, 17'h1FFFF, 0);
		send(KIND_ALLOC, 65537, 0);
		send(KIND_ALLOC, 65536, 0);
		send(KIND_ALLOC, 1, 0);
		send(KIND_ALLOC, 65512, 0);
		send(KIND_FREE, 0, 24);
		send(KIND_ALLOC, 65512, 0);
		send(KIND_FREE, 17'h1FFFF, 16'hFFFF);
		send(KIND_FREE, 0, 0);
		send(KIND_FREE, 0, 24);
		send(KIND_ALLOC, 1, 0);
		send(KIND_ALLOC, 100, 0);
		send(KIND_ALLOC, 65400, 0);
		send(KIND_FREE, 0, 64);
		send(KIND_FREE, 0, 64);
		send(KIND_ALLOC, 20, 0);
		send(KIND_FREE, 0, 24);
		send(KIND_FREE, 0, 64);
		// fill the table to its limit with small grants
		for (int i = 0; i < 70; i++) send(KIND_ALLOC, 16, 0);
		send(KIND_FREE, 0, 0);
		// random, with a calm stretch and a long receiver hold-off
		for (int i = 0; i < 860; i++) begin
			calm = (i >= 300 && i < 420);
			if (i == 500) fork
				begin
					hold_off = 1;
					repeat (600) @(posedge clk);
					hold_off = 0;
				end
			join_none
			send_random();
		end
		in_valid <= 0;
		sending_done = 1;
	end

	initial begin
		wait (sending_done);
		while (sb.exp_status.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
		$display("sent %0d requests, checked %0d results, %0d splits, %0d merges",
			n_sent, sb.n_checked, sb.n_split, sb.n_merge);
		$display("status ok %0d, bad size %0d, no fit %0d, bad address %0d",
			sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3]);
		if (sb.errors == 0 && sb.exp_status.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
